// ===== hw/rtl/psg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and the volume table of the tone, noise and envelope
// sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
   localparam logic [3:0] REG_MIXER        = 4'd7;
   localparam logic [3:0] REG_VOLUME_A     = 4'd8;
   localparam logic [3:0] REG_ENV_FINE     = 4'd11;
   localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
   localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

   localparam int SHAPE_HOLD      = 0;
   localparam int SHAPE_ALTERNATE = 1;
   localparam int SHAPE_ATTACK    = 2;
   localparam int SHAPE_CONTINUE  = 3;
   localparam int VOLUME_ENV_BIT  = 4;
   localparam int MIXER_NOISE_OFS = 3;
   localparam int NUM_CHANNELS    = 3;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_TICK,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
   } req_type;

   typedef struct packed {
      logic [6:0] amplitude;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
   } entry_type;

   function automatic logic [5:0] volume_lookup(input logic [3:0] level);
      logic [5:0] vol;
      case (level)
         4'd0:    vol = 6'd0;
         4'd1:    vol = 6'd1;
         4'd2:    vol = 6'd2;
         4'd3:    vol = 6'd3;
         4'd4:    vol = 6'd4;
         4'd5:    vol = 6'd5;
         4'd6:    vol = 6'd7;
         4'd7:    vol = 6'd10;
         4'd8:    vol = 6'd13;
         4'd9:    vol = 6'd18;
         4'd10:   vol = 6'd24;
         4'd11:   vol = 6'd30;
         4'd12:   vol = 6'd36;
         4'd13:   vol = 6'd40;
         default: vol = 6'd42;
      endcase
      return vol;
   endfunction

endpackage

// ===== hw/rtl/psg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_front
// Accepts request transactions and classifies them into queue entries.
// ----------------------------------------------------------------------------
module psg_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  psg_pkg::req_type    req_payload,
   input  logic                queue_full,
   output logic                push,
   output psg_pkg::entry_type  push_entry
);

   psg_pkg::op_type op;

   always_comb begin
      unique case (req_payload.func)
         psg_pkg::FUNC_WRITE: op = psg_pkg::OP_WRITE;
         psg_pkg::FUNC_TICK:  op = psg_pkg::OP_TICK;
         psg_pkg::FUNC_READ:  op = psg_pkg::OP_READ;
         default:             op = psg_pkg::OP_NONE;
      endcase
   end

   assign req_stall            = queue_full;
   assign push                 = req_valid && !queue_full;
   assign push_entry.op        = op;
   assign push_entry.reg_index = req_payload.reg_index;
   assign push_entry.reg_value = req_payload.reg_value;

endmodule

// ===== hw/rtl/psg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_queue
// Short queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module psg_queue #(
   parameter int DEPTH = psg_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psg_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                head_valid,
   output psg_pkg::entry_type  head_entry,
   output logic                full
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   psg_pkg::entry_type store_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/psg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_back
// Executes writes, reads and generator ticks, mixes the three channels and
// holds the response in an output register.
// ----------------------------------------------------------------------------
module psg_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  psg_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psg_pkg::rsp_type    rsp_payload
);

   localparam int NCH = psg_pkg::NUM_CHANNELS;

   logic [7:0]  regs_ff [16];
   logic [7:0]  regs_in [16];
   logic [11:0] tone_count_ff [NCH];
   logic [11:0] tone_count_in [NCH];
   logic [NCH-1:0] tone_level_ff, tone_level_in;
   logic [5:0]  noise_count_ff, noise_count_in;
   logic [16:0] noise_shift_ff, noise_shift_in;
   logic        noise_level_ff, noise_level_in;
   logic [20:0] env_count_ff, env_count_in;
   logic [4:0]  env_step_ff, env_step_in;
   logic        env_attack_ff, env_attack_in;
   logic [3:0]  env_level_ff, env_level_in;
   logic        rsp_valid_ff, rsp_valid_in;
   psg_pkg::rsp_type rsp_ff, rsp_in;

   logic [11:0] tone_period [NCH];
   logic [11:0] tone_inc [NCH];
   logic [4:0]  noise_period;
   logic [5:0]  noise_inc;
   logic [15:0] env_period;
   logic [20:0] env_inc;
   logic [7:0]  shape;
   logic        shape_attack;
   logic [7:0]  read_data;
   logic [6:0]  amplitude;
   logic [7:0]  mixer;
   logic [7:0]  vol_reg;
   logic [3:0]  vol_level;
   logic        sounds;
   logic        load;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         tone_period[c] = {regs_ff[4'(2 * c + 1)][3:0], regs_ff[4'(2 * c)]};
         if (tone_period[c] == '0) begin
            tone_period[c] = 12'd1;
         end
         tone_inc[c] = tone_count_ff[c] + 12'd1;
      end
      noise_period = regs_ff[psg_pkg::REG_NOISE_PERIOD][4:0];
      if (noise_period == '0) begin
         noise_period = 5'd1;
      end
      noise_inc  = noise_count_ff + 6'd1;
      env_period = {regs_ff[psg_pkg::REG_ENV_COARSE], regs_ff[psg_pkg::REG_ENV_FINE]};
      if (env_period == '0) begin
         env_period = 16'd1;
      end
      env_inc      = env_count_ff + 21'd1;
      shape        = regs_ff[psg_pkg::REG_ENV_SHAPE];
      shape_attack = head_entry.reg_value[psg_pkg::SHAPE_ATTACK];
   end

   always_comb begin
      regs_in        = regs_ff;
      tone_count_in  = tone_count_ff;
      tone_level_in  = tone_level_ff;
      noise_count_in = noise_count_ff;
      noise_shift_in = noise_shift_ff;
      noise_level_in = noise_level_ff;
      env_count_in   = env_count_ff;
      env_step_in    = env_step_ff;
      env_attack_in  = env_attack_ff;
      env_level_in   = env_level_ff;
      read_data      = '0;
      if (load) begin
         unique case (head_entry.op)
            psg_pkg::OP_WRITE: begin
               regs_in[head_entry.reg_index] = head_entry.reg_value;
               if (head_entry.reg_index == psg_pkg::REG_ENV_SHAPE) begin
                  env_step_in   = '0;
                  env_count_in  = '0;
                  env_attack_in = shape_attack;
                  env_level_in  = shape_attack ? 4'd0 : 4'd15;
               end
            end
            psg_pkg::OP_TICK: begin
               for (int c = 0; c < NCH; c++) begin
                  if (tone_inc[c] >= tone_period[c]) begin
                     tone_count_in[c] = '0;
                     tone_level_in[c] = !tone_level_ff[c];
                  end else begin
                     tone_count_in[c] = tone_inc[c];
                  end
               end
               if (noise_inc >= {noise_period, 1'b0}) begin
                  noise_count_in = '0;
                  noise_shift_in = {noise_shift_ff[0] ^ noise_shift_ff[3],
                                    noise_shift_ff[16:1]};
                  noise_level_in = noise_shift_ff[1];
               end else begin
                  noise_count_in = noise_inc;
               end
               if (env_inc >= {env_period, 5'b0}) begin
                  env_count_in = '0;
                  if (!env_step_ff[4]) begin
                     env_level_in = env_attack_ff ? env_step_ff[3:0]
                                                  : 4'd15 - env_step_ff[3:0];
                     env_step_in  = env_step_ff + 5'd1;
                  end else if (!shape[psg_pkg::SHAPE_CONTINUE]) begin
                     env_level_in = '0;
                  end else if (shape[psg_pkg::SHAPE_HOLD]) begin
                     env_level_in = (env_attack_ff ^ shape[psg_pkg::SHAPE_ALTERNATE])
                                    ? 4'd15 : 4'd0;
                  end else begin
                     env_attack_in = env_attack_ff ^ shape[psg_pkg::SHAPE_ALTERNATE];
                     env_step_in   = '0;
                     env_level_in  = env_attack_in ? 4'd0 : 4'd15;
                  end
               end else begin
                  env_count_in = env_inc;
               end
            end
            psg_pkg::OP_READ: begin
               read_data = regs_ff[head_entry.reg_index];
            end
            default: begin
            end
         endcase
      end
   end

   // channel mix from the state after this transaction
   always_comb begin
      amplitude = '0;
      mixer     = regs_in[psg_pkg::REG_MIXER];
      vol_reg   = '0;
      vol_level = '0;
      sounds    = 1'b0;
      for (int c = 0; c < NCH; c++) begin
         vol_reg   = regs_in[4'(int'(psg_pkg::REG_VOLUME_A) + c)];
         vol_level = vol_reg[psg_pkg::VOLUME_ENV_BIT] ? env_level_in : vol_reg[3:0];
         sounds    = (mixer[c] || tone_level_in[c]) &&
                     (mixer[c + psg_pkg::MIXER_NOISE_OFS] || noise_level_in);
         if (sounds) begin
            amplitude = amplitude + {1'b0, psg_pkg::volume_lookup(vol_level)};
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.amplitude   = amplitude;
         rsp_in.read_data   = read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            regs_ff[i] <= '0;
         end
         for (int c = 0; c < NCH; c++) begin
            tone_count_ff[c] <= '0;
         end
         tone_level_ff  <= '0;
         noise_count_ff <= '0;
         noise_shift_ff <= 17'd1;
         noise_level_ff <= 1'b0;
         env_count_ff   <= '0;
         env_step_ff    <= '0;
         env_attack_ff  <= 1'b0;
         env_level_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         regs_ff        <= regs_in;
         tone_count_ff  <= tone_count_in;
         tone_level_ff  <= tone_level_in;
         noise_count_ff <= noise_count_in;
         noise_shift_ff <= noise_shift_in;
         noise_level_ff <= noise_level_in;
         env_count_ff   <= env_count_in;
         env_step_ff    <= env_step_in;
         env_attack_ff  <= env_attack_in;
         env_level_ff   <= env_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (load && head_entry.op != psg_pkg::OP_READ) |=> (rsp_ff.read_data == 8'd0))
      else $error("nonzero read data on a non-read transaction");

   a_amplitude_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.amplitude <= 7'd126))
      else $error("amplitude out of range");

   a_env_step_bound: assert property (@(posedge clock) disable iff (reset)
      env_step_ff <= 5'd16)
      else $error("envelope step beyond sixteen");

endmodule

// ===== hw/rtl/psg_tone_noise_envelope_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_top
// Three-channel tone, noise and envelope sound generator: register writes,
// register reads and generator ticks, each answered with the mixed amplitude.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   func, reg_index, reg_value
//   rsp      out        rsp_valid / rsp_stall   amplitude, read_data
//
// One transaction per cycle sustained while rsp_stall is low; a taken request passes
// the queue stage and then the response register before its response shows.
// Reset is synchronous; registers and generator state clear, but the noise shifter loads 1.
// rsp_stall holds the response register; the queue takes up to QUEUE_DEPTH
// more transactions before req_stall rises.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope_top #(
   parameter int QUEUE_DEPTH = psg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psg_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psg_pkg::rsp_type  rsp_payload
);

   logic               queue_full;
   logic               push;
   psg_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   psg_pkg::entry_type head_entry;

   psg_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   psg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   psg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== test/psg_mix_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_mix_check
// Watches both channels of the sound generator, keeps its own model of the
// register file, tone dividers, noise shifter and envelope, predicts the
// amplitude and read data of every accepted request and compares them with
// the responses in order. Failures and a few coverage counts go to the top.
// ----------------------------------------------------------------------------
module psg_mix_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  psg_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  psg_pkg::rsp_type rsp_payload,
   output int               errors,
   output int               pending,
   output int               tick_count,
   output int               write_count,
   output int               read_count,
   output int               noop_count,
   output int               env_end_count,
   output int               peak_amplitude
);

   // attenuation curve, entry n at bits 6n+5..6n
   localparam logic [95:0] VOL_CURVE = {6'd42, 6'd42, 6'd40, 6'd36, 6'd30, 6'd24,
                                        6'd18, 6'd13, 6'd10, 6'd7,  6'd5,  6'd4,
                                        6'd3,  6'd2,  6'd1,  6'd0};

   logic [7:0]  regs [16];
   logic [11:0] tone_cnt [3];
   logic [2:0]  tone_hi;
   logic [5:0]  noise_cnt;
   logic [16:0] noise_lfsr;
   logic        noise_hi;
   logic [20:0] env_cnt;
   logic [4:0]  env_step;
   logic        env_attack;
   logic [3:0]  env_level;

   psg_pkg::rsp_type expected_mix_q [$];
   psg_pkg::rsp_type want;
   psg_pkg::rsp_type got;

   initial begin
      errors         = 0;
      pending        = 0;
      tick_count     = 0;
      write_count    = 0;
      read_count     = 0;
      noop_count     = 0;
      env_end_count  = 0;
      peak_amplitude = 0;
   end

   task automatic predict_mix(input psg_pkg::req_type item, output psg_pkg::rsp_type result);
      psg_pkg::op_type op;
      logic [7:0] shape;
      logic [7:0] mix;
      logic [7:0] vol_reg;
      int         per;
      int         ch;
      int         lvl;
      int         sum;
      op = psg_pkg::op_type'(item.func);
      result.read_data = 8'd0;
      case (op)
         psg_pkg::OP_WRITE: begin
            write_count++;
            regs[item.reg_index] = item.reg_value;
            if (item.reg_index == psg_pkg::REG_ENV_SHAPE) begin
               env_step   = 5'd0;
               env_cnt    = 21'd0;
               env_attack = item.reg_value[psg_pkg::SHAPE_ATTACK];
               env_level  = env_attack ? 4'd0 : 4'd15;
            end
         end
         psg_pkg::OP_TICK: begin
            tick_count++;
            for (ch = 0; ch < psg_pkg::NUM_CHANNELS; ch++) begin
               tone_cnt[ch] = tone_cnt[ch] + 12'd1;
               per = int'({regs[2 * ch + 1][3:0], regs[2 * ch]});
               if (per == 0) per = 1;
               if (tone_cnt[ch] >= per) begin
                  tone_cnt[ch] = 12'd0;
                  tone_hi[ch]  = ~tone_hi[ch];
               end
            end
            noise_cnt = noise_cnt + 6'd1;
            per = int'(regs[psg_pkg::REG_NOISE_PERIOD][4:0]);
            if (per == 0) per = 1;
            if (noise_cnt >= 2 * per) begin
               noise_cnt  = 6'd0;
               noise_lfsr = {noise_lfsr[0] ^ noise_lfsr[3], noise_lfsr[16:1]};
               noise_hi   = noise_lfsr[0];
            end
            env_cnt = env_cnt + 21'd1;
            per = int'({regs[psg_pkg::REG_ENV_COARSE], regs[psg_pkg::REG_ENV_FINE]});
            if (per == 0) per = 1;
            if (env_cnt >= 32 * per) begin
               shape   = regs[psg_pkg::REG_ENV_SHAPE];
               env_cnt = 21'd0;
               if (env_step < 5'd16) begin
                  env_level = env_attack ? env_step[3:0] : 4'd15 - env_step[3:0];
                  env_step  = env_step + 5'd1;
               end else begin
                  env_end_count++;
                  if (!shape[psg_pkg::SHAPE_CONTINUE]) begin
                     env_level = 4'd0;
                  end else if (shape[psg_pkg::SHAPE_HOLD]) begin
                     env_level = (env_attack ^ shape[psg_pkg::SHAPE_ALTERNATE]) ? 4'd15 : 4'd0;
                  end else begin
                     if (shape[psg_pkg::SHAPE_ALTERNATE]) env_attack = ~env_attack;
                     env_step  = 5'd0;
                     env_level = env_attack ? 4'd0 : 4'd15;
                  end
               end
            end
         end
         psg_pkg::OP_READ: begin
            read_count++;
            result.read_data = regs[item.reg_index];
         end
         default: begin
            noop_count++;
         end
      endcase
      mix = regs[psg_pkg::REG_MIXER];
      sum = 0;
      for (ch = 0; ch < psg_pkg::NUM_CHANNELS; ch++) begin
         vol_reg = regs[psg_pkg::REG_VOLUME_A + ch];
         if ((mix[ch] || tone_hi[ch]) &&
             (mix[ch + psg_pkg::MIXER_NOISE_OFS] || noise_hi)) begin
            lvl = int'(vol_reg[psg_pkg::VOLUME_ENV_BIT] ? env_level : vol_reg[3:0]);
            sum += int'(VOL_CURVE[6 * lvl +: 6]);
         end
      end
      if (sum > peak_amplitude) peak_amplitude = sum;
      result.amplitude = 7'(sum);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs[i] = 8'd0;
         for (int i = 0; i < psg_pkg::NUM_CHANNELS; i++) tone_cnt[i] = 12'd0;
         tone_hi    = 3'd0;
         noise_cnt  = 6'd0;
         noise_lfsr = 17'd1;
         noise_hi   = 1'b0;
         env_cnt    = 21'd0;
         env_step   = 5'd0;
         env_attack = 1'b0;
         env_level  = 4'd0;
         expected_mix_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_mix_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with nothing outstanding: amplitude %0d read_data %0h",
                           $time, got.amplitude, got.read_data);
            end else begin
               want = expected_mix_q.pop_front();
               if (got.amplitude !== want.amplitude || got.read_data !== want.read_data) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch amplitude exp %0d got %0d, read_data exp %0h got %0h",
                              $time, want.amplitude, got.amplitude, want.read_data,
                              got.read_data);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_mix(req_payload, want);
            expected_mix_q.push_back(want);
         end
      end
      pending = expected_mix_q.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tone, noise and envelope sound generator.
// A short directed part hits register extremes, zero periods, shape restarts
// and the unused opcode; then configuration bursts followed by long tick runs
// drive the envelope through its end behavior, under four idling phases and
// a long response hold-off every fourth sequence. Checking lives in psg_mix_check.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_ITEMS    = 1200;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam logic [3:0] REG_TONE_FINE_A   = 4'd0;
   localparam logic [3:0] REG_TONE_COARSE_A = 4'd1;
   localparam logic [3:0] REG_SPARE_A       = 4'd14;
   localparam logic [3:0] REG_SPARE_B       = 4'd15;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   psg_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   psg_pkg::rsp_type rsp_payload;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_off_req   = 1'b0;
   int   hold_left      = 0;
   int   random_sent    = 0;

   int errors, pending, tick_count, write_count, read_count, noop_count;
   int env_end_count, peak_amplitude;

   always #5 clock = ~clock;

   psg_tone_noise_envelope_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   psg_mix_check mix_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .errors         (errors),
      .pending        (pending),
      .tick_count     (tick_count),
      .write_count    (write_count),
      .read_count     (read_count),
      .noop_count     (noop_count),
      .env_end_count  (env_end_count),
      .peak_amplitude (peak_amplitude)
   );

   // response side, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // returns right after the accepting edge, valid still high
   task automatic send_op(input psg_pkg::op_type op, input logic [3:0] idx,
                          input logic [7:0] val);
      psg_pkg::req_type item;
      item.func      = op;
      item.reg_index = idx;
      item.reg_value = val;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 84)
         send_op(psg_pkg::OP_TICK, 4'($urandom), 8'($urandom));
      else if (pick < 92)
         send_op(psg_pkg::OP_READ, 4'($urandom), 8'($urandom));
      else if (pick < 97)
         send_op(psg_pkg::OP_WRITE, ($urandom_range(0, 1) ? 4'($urandom_range(0, 10))
                                                          : 4'($urandom_range(14, 15))),
                 8'($urandom));
      else
         send_op(psg_pkg::op_type'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
      random_sent++;
   endtask

   initial begin
      int seq_count;
      int run_len;
      logic [7:0] val;
      seq_count = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed
      send_op(psg_pkg::OP_READ, REG_TONE_FINE_A, 8'h00);
      send_op(psg_pkg::OP_NONE, REG_SPARE_B, 8'hff);
      send_op(psg_pkg::OP_WRITE, REG_SPARE_B, 8'hff);
      send_op(psg_pkg::OP_READ, REG_SPARE_B, 8'h00);
      send_op(psg_pkg::OP_WRITE, REG_SPARE_A, 8'ha5);
      send_op(psg_pkg::OP_READ, REG_SPARE_A, 8'hff);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_MIXER, 8'hff);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_VOLUME_A, 8'h0f);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_VOLUME_A + 4'd1, 8'h1f);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_VOLUME_A + 4'd2, 8'hef);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_SHAPE, 8'h00);
      send_op(psg_pkg::OP_TICK, 4'd0, 8'h00);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_SHAPE, 8'hff);
      send_op(psg_pkg::OP_READ, psg_pkg::REG_ENV_SHAPE, 8'h00);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_NOISE_PERIOD, 8'hff);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_MIXER, 8'h00);
      send_op(psg_pkg::OP_TICK, 4'hf, 8'hff);
      send_op(psg_pkg::OP_TICK, 4'd0, 8'h00);
      send_op(psg_pkg::OP_WRITE, REG_TONE_FINE_A, 8'hff);
      send_op(psg_pkg::OP_WRITE, REG_TONE_COARSE_A, 8'hff);
      send_op(psg_pkg::OP_TICK, 4'd0, 8'h00);
      send_op(psg_pkg::OP_READ, psg_pkg::REG_MIXER, 8'h00);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_COARSE, 8'hff);
      send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_COARSE, 8'h00);

      // configuration burst in most sequences, then a tick run, per sequence
      while (random_sent < RANDOM_ITEMS) begin
         case (seq_count % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         if ($urandom_range(0, 4) != 0) begin
            for (int ch = 0; ch < psg_pkg::NUM_CHANNELS; ch++) begin
               send_op(psg_pkg::OP_WRITE, 4'(2 * ch), ($urandom_range(0, 3) == 0)
                                                      ? 8'($urandom)
                                                      : 8'($urandom_range(0, 12)));
               val = {4'($urandom), ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h0};
               send_op(psg_pkg::OP_WRITE, 4'(2 * ch + 1), val);
               val = 8'($urandom);
               val[psg_pkg::VOLUME_ENV_BIT] = 1'($urandom_range(0, 1));
               send_op(psg_pkg::OP_WRITE, psg_pkg::REG_VOLUME_A + 4'(ch), val);
            end
            send_op(psg_pkg::OP_WRITE, psg_pkg::REG_NOISE_PERIOD, 8'($urandom));
            send_op(psg_pkg::OP_WRITE, psg_pkg::REG_MIXER, 8'($urandom));
            send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_FINE, ($urandom_range(0, 3) == 0)
                                      ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 1)));
            send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_COARSE,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
            send_op(psg_pkg::OP_WRITE, psg_pkg::REG_ENV_SHAPE, 8'($urandom));
            random_sent += 14;
         end
         if (seq_count % 4 == 0) hold_off_req = 1'b1;
         run_len = $urandom_range(24, 600);
         for (int i = 0; i < run_len && random_sent < RANDOM_ITEMS; i++) send_random();
         seq_count++;
      end

      @(negedge clock);
      req_valid     <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait (pending == 0);
      repeat (10) @(posedge clock);

      $display("covered %0d transactions: %0d ticks, %0d writes, %0d reads, %0d unused opcodes",
               tick_count + write_count + read_count + noop_count, tick_count, write_count,
               read_count, noop_count);
      $display("envelope went past its last step %0d times, peak amplitude %0d",
               env_end_count, peak_amplitude);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
